FILE: hdl/canonical_kmer_tag_counter_defines.svh
// Assertion macros shared by the k-mer tag counter modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CANONICAL_KMER_TAG_COUNTER_DEFINES_SVH
`define CANONICAL_KMER_TAG_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CKT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("canonical_kmer_tag_counter assertion failed");

// Next-cycle implication, disabled during reset.
`define CKT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("canonical_kmer_tag_counter assertion failed");

`endif

FILE: hdl/ckt_pkg.sv
// Types and constants of the k-mer tag counter.
// Used by the front, queue, back and top modules; depends on nothing.
package ckt_pkg;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BASE  = 2'd1,
      OP_START = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   localparam logic [1:0] REG_KMER_LENGTH  = 2'd0;
   localparam logic [1:0] REG_STRANDED     = 2'd1;
   localparam logic [1:0] REG_REVERSE_ONLY = 2'd2;

   localparam logic [5:0] KMER_LENGTH_RESET = 6'd22;
   localparam int         SLOT_EXT_W        = 13;

   typedef struct packed {
      op_type      op;
      logic        kmer_valid;
      logic [63:0] kmer_code;
      logic [63:0] tag_code;
      logic [7:0]  slot;
   } cmd_type;

   typedef struct packed {
      logic        kmer_valid;
      logic [63:0] kmer_code;
      logic        hit;
      logic [7:0]  hit_slot;
      logic [31:0] count;
   } rsp_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_SCAN,
      B_QREAD,
      B_DONE
   } back_state_type;

endpackage

FILE: hdl/ckt_front.sv
// Front end: accepts items, holds the configuration and the rolling windows,
// and forms the selected k-mer. Depends on ckt_pkg.
module ckt_front
   import ckt_pkg::*;
#(
   parameter int MAX_KMER = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_op,
   input  logic [1:0]  req_base,
   input  logic [63:0] req_tag_code,
   input  logic [7:0]  req_slot,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_wdata,
   output logic        cmd_push,
   output cmd_type     cmd,
   input  logic        cmd_full
);

   localparam logic [5:0] MAX_K = 6'(MAX_KMER);

   logic [5:0]  kmer_length_ff, kmer_length_in;
   logic        stranded_ff, stranded_in;
   logic        reverse_only_ff, reverse_only_in;
   logic [63:0] fwd_ff, fwd_in;
   logic [63:0] rev_ff, rev_in;
   logic [5:0]  fill_ff, fill_in;
   logic [5:0]  eff_k;
   logic [63:0] mask;
   logic [63:0] fwd_next;
   logic [63:0] rev_next;
   logic [5:0]  fill_next;
   logic [6:0]  top_shift;
   logic        accept;
   logic        csr_write;

   assign full      = cmd_full;
   assign csr_ready = 1'b1;
   assign accept    = push && !cmd_full;
   assign csr_write = csr_valid && csr_ready;
   assign cmd_push  = accept;

   always_comb begin
      if (kmer_length_ff == 6'd0) begin
         eff_k = 6'd1;
      end else if (kmer_length_ff > MAX_K) begin
         eff_k = MAX_K;
      end else begin
         eff_k = kmer_length_ff;
      end
      if (eff_k >= 6'd32) begin
         mask = '1;
      end else begin
         mask = (64'd1 << {eff_k, 1'b0}) - 64'd1;
      end
      top_shift = {eff_k, 1'b0} - 7'd2;
      fwd_next  = ((fwd_ff << 2) | {62'd0, req_base}) & mask;
      rev_next  = ((rev_ff >> 2) | ({62'd0, ~req_base} << top_shift)) & mask;
      fill_next = (fill_ff < MAX_K) ? fill_ff + 6'd1 : fill_ff;
   end

   always_comb begin
      cmd.op         = op_type'(req_op);
      cmd.tag_code   = req_tag_code;
      cmd.slot       = req_slot;
      cmd.kmer_valid = (fill_next >= eff_k);
      if (reverse_only_ff) begin
         cmd.kmer_code = rev_next;
      end else if (stranded_ff || (fwd_next < rev_next)) begin
         cmd.kmer_code = fwd_next;
      end else begin
         cmd.kmer_code = rev_next;
      end
      if (req_op != OP_BASE) begin
         cmd.kmer_valid = 1'b0;
         cmd.kmer_code  = '0;
      end else if (!cmd.kmer_valid) begin
         cmd.kmer_code = '0;
      end
   end

   always_comb begin
      kmer_length_in  = kmer_length_ff;
      stranded_in     = stranded_ff;
      reverse_only_in = reverse_only_ff;
      fwd_in          = fwd_ff;
      rev_in          = rev_ff;
      fill_in         = fill_ff;
      if (accept) begin
         case (op_type'(req_op))
            OP_BASE: begin
               fwd_in  = fwd_next;
               rev_in  = rev_next;
               fill_in = fill_next;
            end
            OP_START: begin
               fwd_in  = '0;
               rev_in  = '0;
               fill_in = '0;
            end
            default: begin
            end
         endcase
      end
      if (csr_write) begin
         case (csr_index)
            REG_KMER_LENGTH: begin
               kmer_length_in = csr_wdata;
               fwd_in         = '0;
               rev_in         = '0;
               fill_in        = '0;
            end
            REG_STRANDED:     stranded_in     = csr_wdata[0];
            REG_REVERSE_ONLY: reverse_only_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_length_ff  <= KMER_LENGTH_RESET;
         stranded_ff     <= 1'b0;
         reverse_only_ff <= 1'b0;
         fwd_ff          <= '0;
         rev_ff          <= '0;
         fill_ff         <= '0;
      end else begin
         kmer_length_ff  <= kmer_length_in;
         stranded_ff     <= stranded_in;
         reverse_only_ff <= reverse_only_in;
         fwd_ff          <= fwd_in;
         rev_ff          <= rev_in;
         fill_ff         <= fill_in;
      end
   end

endmodule

FILE: hdl/ckt_fifo.sv
// Two-word command queue between the front and back ends.
// Depends on ckt_pkg and the assertion macro header.
`include "canonical_kmer_tag_counter_defines.svh"
module ckt_fifo
   import ckt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_data,
   output logic    full,
   input  logic    rd_en,
   output cmd_type rd_data,
   output logic    empty
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr;
   logic       do_rd;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `CKT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= 2'd2)

endmodule

FILE: hdl/ckt_back.sv
// Back end: tag and count memories, valid bits, slot scan and result register.
// Depends on ckt_pkg and the assertion macro header.
`include "canonical_kmer_tag_counter_defines.svh"
module ckt_back
   import ckt_pkg::*;
#(
   parameter int TAG_SLOTS = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  logic    cmd_empty,
   output logic    cmd_pop,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp
);

   localparam int                    SW   = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
   localparam logic [SLOT_EXT_W-1:0] LAST = SLOT_EXT_W'(TAG_SLOTS - 1);
   localparam logic [SLOT_EXT_W-1:0] NUM  = SLOT_EXT_W'(TAG_SLOTS);

   logic [63:0] tag_mem [TAG_SLOTS];
   logic [31:0] cnt_mem [TAG_SLOTS];

   back_state_type         state_ff, state_in;
   logic [TAG_SLOTS-1:0]   valid_ff, valid_in;
   logic [SW-1:0]          rd_idx_ff;
   logic [SW-1:0]          rd_addr;
   logic [63:0]            rd_tag_ff;
   logic [31:0]            rd_cnt_ff;
   rsp_type                res_ff, res_in;
   rsp_type                out_ff;
   logic                   out_valid_ff, out_valid_in;
   logic                   out_load;
   logic                   tag_we;
   logic                   cnt_we;
   logic [SW-1:0]          wr_addr;
   logic [31:0]            cnt_wdata;
   logic [SLOT_EXT_W-1:0]  slot_ext;
   logic [SLOT_EXT_W-1:0]  idx_ext;
   logic [SW-1:0]          cmd_idx;
   logic                   in_range;
   logic                   match;

   assign slot_ext = {{(SLOT_EXT_W-8){1'b0}}, cmd.slot};
   assign cmd_idx  = slot_ext[SW-1:0];
   assign in_range = (slot_ext < NUM);
   assign idx_ext  = SLOT_EXT_W'(rd_idx_ff);
   assign match    = valid_ff[rd_idx_ff] && (rd_tag_ff == res_ff.kmer_code);
   assign empty    = !out_valid_ff;
   assign rsp      = out_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!cmd_empty) begin
               case (cmd.op)
                  OP_QUERY: state_in = (in_range && valid_ff[cmd_idx]) ? B_QREAD : B_DONE;
                  OP_BASE:  state_in = cmd.kmer_valid ? B_SCAN : B_DONE;
                  default:  state_in = B_DONE;
               endcase
            end
         end
         B_SCAN: begin
            if (match || (idx_ext == LAST)) begin
               state_in = B_DONE;
            end
         end
         B_QREAD: state_in = B_DONE;
         B_DONE: begin
            if (out_load) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop   = 1'b0;
      rd_addr   = rd_idx_ff;
      tag_we    = 1'b0;
      cnt_we    = 1'b0;
      wr_addr   = cmd_idx;
      cnt_wdata = '0;
      valid_in  = valid_ff;
      res_in    = res_ff;
      out_load  = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b0 == 1'b0;
               res_in  = '0;
               case (cmd.op)
                  OP_LOAD: begin
                     if (in_range) begin
                        tag_we            = 1'b1;
                        cnt_we            = 1'b1;
                        valid_in[cmd_idx] = 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     res_in.hit_slot = cmd.slot;
                     rd_addr         = cmd_idx;
                  end
                  OP_BASE: begin
                     res_in.kmer_valid = cmd.kmer_valid;
                     res_in.kmer_code  = cmd.kmer_code;
                     rd_addr           = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         B_SCAN: begin
            if (match) begin
               cnt_we          = 1'b1;
               wr_addr         = rd_idx_ff;
               cnt_wdata       = (rd_cnt_ff == '1) ? rd_cnt_ff : rd_cnt_ff + 32'd1;
               res_in.hit      = 1'b1;
               res_in.hit_slot = idx_ext[7:0];
               res_in.count    = cnt_wdata;
            end else begin
               rd_addr = rd_idx_ff + SW'(1);
            end
         end
         B_QREAD: begin
            res_in.hit   = 1'b1;
            res_in.count = rd_cnt_ff;
         end
         B_DONE: begin
            out_load = !out_valid_ff || pop;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_addr;
      res_ff    <= res_in;
      if (out_load) begin
         out_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[wr_addr] <= cmd.tag_code;
      end
      rd_tag_ff <= tag_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[wr_addr] <= cnt_wdata;
      end
      rd_cnt_ff <= cnt_mem[rd_addr];
   end

   `CKT_ASSERT_NOW(a_no_overwrite, clock, reset, out_load, !out_valid_ff || pop)
   `CKT_ASSERT_NOW(a_scan_in_range, clock, reset, state_ff == B_SCAN, idx_ext < NUM)
   `CKT_ASSERT_NOW(a_hit_nonzero, clock, reset, out_load && res_ff.hit && res_ff.kmer_valid,
                   res_ff.count != 32'd0)
   `CKT_ASSERT_NEXT(a_pop_leaves_idle, clock, reset, cmd_pop, state_ff != B_IDLE)

endmodule

FILE: hdl/canonical_kmer_tag_counter.sv
// A query of a loaded slot reads the count memory; a base whose k-mer is complete makes the
// back end scan the tag memory one slot per cycle from slot 0 until a hit or the last slot.
// The back end takes a new word only after the result of the last has entered the output
// register, so a stall on the result side holds it; the front queue holds two words.
// Reset clears configuration, windows and slot valid bits; memories are not cleared.
module canonical_kmer_tag_counter
   import ckt_pkg::*;
#(
   parameter int TAG_SLOTS = 256,
   parameter int MAX_KMER  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_op,
   input  logic [1:0]  req_base,
   input  logic [63:0] req_tag_code,
   input  logic [7:0]  req_slot,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kmer_valid,
   output logic [63:0] rsp_kmer_code,
   output logic        rsp_hit,
   output logic [7:0]  rsp_hit_slot,
   output logic [31:0] rsp_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_wdata
);

   cmd_type front_cmd;
   cmd_type back_cmd;
   logic    cmd_push;
   logic    cmd_full;
   logic    cmd_empty;
   logic    cmd_pop;
   rsp_type rsp;

   ckt_front #(.MAX_KMER(MAX_KMER)) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_op       (req_op),
      .req_base     (req_base),
      .req_tag_code (req_tag_code),
      .req_slot     (req_slot),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd_push     (cmd_push),
      .cmd          (front_cmd),
      .cmd_full     (cmd_full)
   );

   ckt_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (front_cmd),
      .full    (cmd_full),
      .rd_en   (cmd_pop),
      .rd_data (back_cmd),
      .empty   (cmd_empty)
   );

   ckt_back #(.TAG_SLOTS(TAG_SLOTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp       (rsp)
   );

   assign rsp_kmer_valid = rsp.kmer_valid;
   assign rsp_kmer_code  = rsp.kmer_code;
   assign rsp_hit        = rsp.hit;
   assign rsp_hit_slot   = rsp.hit_slot;
   assign rsp_count      = rsp.count;

endmodule

FILE: test/tb_canonical_kmer_tag_counter.sv
// Self-checking testbench of the k-mer tag counter: random reads and tag loads
// under several register settings, checked against an in-bench predictor.
// Depends on ckt_pkg and the canonical_kmer_tag_counter top module.
module tb_canonical_kmer_tag_counter
   import ckt_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      op_type      op;
      logic [1:0]  base;
      logic [63:0] code;
      logic [7:0]  slot;
   } word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_op = '0;
   logic [1:0]  req_base = '0;
   logic [63:0] req_tag_code = '0;
   logic [7:0]  req_slot = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_kmer_valid;
   logic [63:0] rsp_kmer_code;
   logic        rsp_hit;
   logic [7:0]  rsp_hit_slot;
   logic [31:0] rsp_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [5:0]  csr_wdata = '0;

   canonical_kmer_tag_counter dut (.*);

   word_type pending_words[$];
   rsp_type  expected_rsps[$];
   word_type cur_word;
   int       errors = 0;
   int       rsp_seen = 0;
   int       hold_cycles = 0;
   bit       held = 0;
   bit       calm = 0;
   longint   cycles = 0;

   logic [5:0]  len_reg;
   logic        stranded_reg;
   logic        reverse_reg;
   logic [63:0] fwd_win, rev_win;
   int          fill;
   logic [63:0] tag_mem[256];
   bit          tag_ok[256];
   logic [31:0] tag_cnt[256];

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int eff_len();
      int k;
      k = len_reg;
      if (k < 1) k = 1;
      if (k > 32) k = 32;
      return k;
   endfunction

   function automatic logic [63:0] len_mask(int k);
      return (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
   endfunction

   function automatic logic [63:0] pick_kmer(logic [63:0] f, logic [63:0] r);
      if (reverse_reg) return r;
      if (stranded_reg || f < r) return f;
      return r;
   endfunction

   function automatic rsp_type tally_word(word_type w);
      rsp_type     r;
      int          k;
      logic [63:0] m, sel;
      r = '0;
      case (w.op)
         OP_LOAD: begin
            tag_mem[w.slot] = w.code;
            tag_ok[w.slot] = 1;
            tag_cnt[w.slot] = 32'd0;
         end
         OP_START: begin
            fwd_win = 0;
            rev_win = 0;
            fill = 0;
         end
         OP_QUERY: begin
            r.hit_slot = w.slot;
            if (tag_ok[w.slot]) begin
               r.hit = 1;
               r.count = tag_cnt[w.slot];
            end
         end
         default: begin
            k = eff_len();
            m = len_mask(k);
            fwd_win = ((fwd_win << 2) | 64'(w.base)) & m;
            rev_win = ((rev_win >> 2) | (64'(2'd3 - w.base) << (2 * k - 2))) & m;
            if (fill < 32) fill++;
            if (fill >= k) begin
               sel = pick_kmer(fwd_win, rev_win);
               r.kmer_valid = 1;
               r.kmer_code = sel;
               for (int s = 0; s < 256; s++) begin
                  if (tag_ok[s] && tag_mem[s] == sel) begin
                     if (tag_cnt[s] != 32'hffffffff) tag_cnt[s]++;
                     r.hit = 1;
                     r.hit_slot = 8'(s);
                     r.count = tag_cnt[s];
                     break;
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         push <= 0;
      end else begin
         if (push && !full) expected_rsps.insert(expected_rsps.size(), tally_word(cur_word));
         if (!push || !full) begin
            if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
               cur_word = pending_words.pop_front();
               req_op <= cur_word.op;
               req_base <= cur_word.base;
               req_tag_code <= cur_word.code;
               req_slot <= cur_word.slot;
               push <= 1;
            end else begin
               push <= 0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
         $display("%0t %s mismatch: expected %h actual %h", $realtime, name, e, a);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         pop <= 0;
      end else begin
         if (pop && !empty) begin
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
               $display("%0t unexpected word: expected none actual code %h",
                        $realtime, rsp_kmer_code);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               check_field("kmer_valid", e.kmer_valid, rsp_kmer_valid);
               check_field("kmer_code", e.kmer_code, rsp_kmer_code);
               check_field("hit", e.hit, rsp_hit);
               check_field("hit_slot", e.hit_slot, rsp_hit_slot);
               check_field("count", e.count, rsp_count);
            end
         end
         if (rsp_seen >= 120 && pending_words.size() > 20 && !held) begin
            held = 1;
            hold_cycles = 3000;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            pop <= 0;
         end else begin
            pop <= calm || $urandom_range(99) >= 24;
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [5:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      case (idx)
         REG_KMER_LENGTH: begin
            len_reg = val;
            fwd_win = 0;
            rev_win = 0;
            fill = 0;
         end
         REG_STRANDED: stranded_reg = val[0];
         REG_REVERSE_ONLY: reverse_reg = val[0];
         default: ;
      endcase
   endtask

   task automatic add_word(op_type op, logic [1:0] b, logic [63:0] c, logic [7:0] s);
      word_type w;
      w.op = op;
      w.base = b;
      w.code = c;
      w.slot = s;
      pending_words.insert(pending_words.size(), w);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_words.size() != 0 || push || expected_rsps.size() != 0);
      repeat (300) @(posedge clock);
   endtask

   // One read: up to two of its own k-mers are loaded as tags first so hits occur.
   task automatic add_read(int len);
      logic [1:0]  seq[$];
      logic [63:0] f, r;
      int          k, p;
      k = eff_len();
      for (int i = 0; i < len; i++) seq.insert(seq.size(), 2'($urandom_range(3)));
      for (int n = 0; n < 2 && len >= k; n++) begin
         p = $urandom_range(len - 1, k - 1);
         f = 0;
         r = 0;
         for (int i = 0; i < k; i++) begin
            f = (f << 2) | 64'(seq[p - k + 1 + i]);
            r = r | (64'(2'd3 - seq[p - k + 1 + i]) << (2 * i));
         end
         add_word(OP_LOAD, 2'($urandom), pick_kmer(f, r), 8'($urandom));
      end
      add_word(OP_START, 2'($urandom), {$urandom, $urandom}, 8'($urandom));
      foreach (seq[i]) add_word(OP_BASE, seq[i], {$urandom, $urandom}, 8'($urandom));
   endtask

   initial begin
      logic [5:0] lens[9] = '{6'd22, 6'd1, 6'd0, 6'd32, 6'd63, 6'd3, 6'd5, 6'd12, 6'd2};
      int sel;
      len_reg = KMER_LENGTH_RESET;
      stranded_reg = 0;
      reverse_reg = 0;
      fwd_win = 0;
      rev_win = 0;
      fill = 0;
      for (int s = 0; s < 256; s++) begin
         tag_ok[s] = 0;
         tag_cnt[s] = 0;
         tag_mem[s] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 0;

      // Directed: extremes of codes and slots, every op, unloaded queries.
      add_word(OP_QUERY, 2'd0, '0, 8'd255);
      add_word(OP_QUERY, 2'd3, '1, 8'd0);
      add_word(OP_LOAD, 2'd0, '0, 8'd0);
      add_word(OP_LOAD, 2'd3, '1, 8'd255);
      add_word(OP_QUERY, 2'd0, '0, 8'd255);
      add_word(OP_START, 2'd0, '0, 8'd0);
      for (int i = 0; i < 4; i++) add_word(OP_BASE, 2'(i), '0, 8'd0);
      add_word(OP_QUERY, 2'd0, '0, 8'd0);
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         write_reg(REG_KMER_LENGTH, lens[ph]);
         write_reg(REG_STRANDED, ph[0]);
         write_reg(REG_REVERSE_ONLY, (ph % 3) == 2);
         calm = (ph == 4);
         if (ph == 1) begin
            // With k of one, every base matches a loaded single-base tag.
            for (int i = 0; i < 4; i++) add_word(OP_LOAD, 2'd0, 64'(i), 8'(10 + i));
            add_word(OP_LOAD, 2'd0, 64'd1 | (64'd1 << 63), 8'd20);
            add_word(OP_START, 2'd0, '0, 8'd0);
            for (int i = 0; i < 8; i++) add_word(OP_BASE, 2'(i), '0, 8'd0);
            for (int i = 0; i < 4; i++) add_word(OP_QUERY, 2'd0, '0, 8'(10 + i));
         end
         for (int n = 0; n < 5; n++) begin
            add_read($urandom_range(eff_len() + 6, 1));
            for (int q = 0; q < 2; q++) begin
               sel = $urandom_range(99);
               if (sel < 60)
                  add_word(OP_QUERY, 2'($urandom), {$urandom, $urandom}, 8'($urandom));
               else if (sel < 80)
                  add_word(OP_LOAD, 2'($urandom), {$urandom, $urandom}, 8'($urandom));
               else
                  add_word(OP_BASE, 2'($urandom), {$urandom, $urandom}, 8'($urandom));
            end
         end
         drain();
      end

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
